>>> rtl/core/longest_remaining_job_scheduler_defines.svh
// Assertion helpers shared by the scheduler RTL.
`ifndef LONGEST_REMAINING_JOB_SCHEDULER_DEFINES_SVH
`define LONGEST_REMAINING_JOB_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define LRJS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrjs: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define LRJS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrjs: next-cycle check failed");

`endif

>>> rtl/core/lrjs_pkg.sv
package lrjs_pkg;

    // Field widths
    localparam int ARR_W       = 12;
    localparam int BUR_W       = 12;
    localparam int IDX_OUT_W   = 4;
    localparam int RES_W       = 17;
    localparam int TOT_W       = 21;
    localparam int DEF_MAX_JOBS = 16;

    // Input beat
    typedef struct packed {
        logic [ARR_W-1:0] arrival_time;
        logic [BUR_W-1:0] burst_length;
        logic             last_job;
    } t_job_in;

    // Result beat
    typedef struct packed {
        logic [IDX_OUT_W-1:0] job_index;
        logic [RES_W-1:0]     completion_time;
        logic [RES_W-1:0]     turnaround;
        logic [RES_W-1:0]     waiting;
        logic [TOT_W-1:0]     total_turnaround;
        logic [TOT_W-1:0]     total_waiting;
        logic                 overflowed;
        logic                 last_result;
    } t_job_res;

    // Controller to datapath commands
    typedef struct packed {
        logic load_wr;    // store an input job
        logic scan_clr;   // restart the table scan
        logic scan_rd;    // read next entry of the scan
        logic time_step;  // run best job for one unit
        logic time_skip;  // jump time to next arrival
        logic out_clr;    // restart result readout
        logic out_rd;     // read entry for next result
        logic out_load;   // fill the result register
        logic set_clear;  // end of set: clear count, time, overflow
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic idx_last;    // scan read address is the last stored entry
        logic best_valid;  // an arrived unfinished job was found
        logic any_unf;     // some job is unfinished
        logic out_fire;    // result beat taken this cycle
        logic res_last;    // held result is the final one
    } t_status;

endpackage

>>> rtl/core/lrjs_ctrl.sv
module lrjs_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_last_job,
    output logic             o_in_ready,
    input  lrjs_pkg::t_status i_status,
    output lrjs_pkg::t_cmd    o_cmd
);
    import lrjs_pkg::*;

    typedef enum logic [6:0] {
        S_LOAD     = 7'b0000001,
        S_SCAN     = 7'b0000010,
        S_WAIT     = 7'b0000100,
        S_DECIDE   = 7'b0001000,
        S_OUT_RD   = 7'b0010000,
        S_OUT_CALC = 7'b0100000,
        S_OUT_HOLD = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and command decode
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_last_job) begin
                        o_cmd.scan_clr = 1'b1;
                        n_state        = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.idx_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                // last read entry gets evaluated here
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.best_valid) begin
                    o_cmd.time_step = 1'b1;
                    o_cmd.scan_clr  = 1'b1;
                    n_state         = S_SCAN;
                end else if (i_status.any_unf) begin
                    o_cmd.time_skip = 1'b1;
                    o_cmd.scan_clr  = 1'b1;
                    n_state         = S_SCAN;
                end else begin
                    o_cmd.out_clr = 1'b1;
                    n_state       = S_OUT_RD;
                end
            end
            S_OUT_RD: begin
                o_cmd.out_rd = 1'b1;
                n_state      = S_OUT_CALC;
            end
            S_OUT_CALC: begin
                o_cmd.out_load = 1'b1;
                n_state        = S_OUT_HOLD;
            end
            S_OUT_HOLD: begin
                if (i_status.out_fire) begin
                    if (i_status.res_last) begin
                        o_cmd.set_clear = 1'b1;
                        n_state         = S_LOAD;
                    end else begin
                        n_state = S_OUT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/lrjs_dp.sv
`include "longest_remaining_job_scheduler_defines.svh"

module lrjs_dp #(
    parameter int MAX_JOBS = lrjs_pkg::DEF_MAX_JOBS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lrjs_pkg::t_job_in  i_in_data,
    input  lrjs_pkg::t_cmd     i_cmd,
    output lrjs_pkg::t_status  o_status,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lrjs_pkg::t_job_res o_out_data
);
    import lrjs_pkg::*;

    localparam int IDX_W    = $clog2(MAX_JOBS);
    localparam int CNT_W    = $clog2(MAX_JOBS + 1);
    // latest time: last arrival plus every burst
    localparam int TIME_RAW = $clog2((1 << ARR_W) * (MAX_JOBS + 1));
    localparam int TIME_W   = (TIME_RAW > RES_W) ? TIME_RAW : RES_W;

    // Job table, one entry per stored job
    logic [ARR_W-1:0]  mem_arr  [MAX_JOBS];
    logic [BUR_W-1:0]  mem_bur  [MAX_JOBS];
    logic [BUR_W-1:0]  mem_rem  [MAX_JOBS];
    logic [TIME_W-1:0] mem_done [MAX_JOBS];

    // Control registers
    logic [CNT_W-1:0]  r_count;
    logic [TIME_W-1:0] r_time;
    logic              r_ovf;
    logic [IDX_W-1:0]  r_scan_idx;
    logic              r_eval_vld;
    logic              r_best_vld;
    logic              r_any_unf;
    logic [IDX_W-1:0]  r_out_idx;
    logic              r_out_valid;
    logic [TOT_W-1:0]  r_tot_tat;
    logic [TOT_W-1:0]  r_tot_wt;

    // Payload registers
    logic [ARR_W-1:0]  r_rd_arr;
    logic [BUR_W-1:0]  r_rd_bur;
    logic [BUR_W-1:0]  r_rd_rem;
    logic [TIME_W-1:0] r_rd_done;
    logic [IDX_W-1:0]  r_eval_idx;
    logic [IDX_W-1:0]  r_best_idx;
    logic [ARR_W-1:0]  r_best_arr;
    logic [BUR_W-1:0]  r_best_bur;
    logic [BUR_W-1:0]  r_best_rem;
    logic [TIME_W-1:0] r_best_done;
    logic [ARR_W-1:0]  r_min_arr;
    t_job_res          r_out_data;

    logic                 w_has_room;
    logic                 w_wr_en;
    logic [IDX_W-1:0]     w_wr_addr;
    logic [ARR_W-1:0]     w_wr_arr;
    logic [BUR_W-1:0]     w_wr_bur;
    logic [BUR_W-1:0]     w_wr_rem;
    logic [TIME_W-1:0]    w_wr_done;
    logic                 w_rd_en;
    logic [IDX_W-1:0]     w_rd_addr;
    logic                 w_unf;
    logic                 w_arrived;
    logic                 w_better;
    logic [TIME_W-1:0]    w_tat;
    logic [TIME_W-1:0]    w_wt;
    logic                 w_out_last;
    logic [IDX_OUT_W-1:0] w_idx_out;
    logic                 w_out_fire;
    logic                 w_skip_fwd;

    assign w_has_room = r_count < CNT_W'(MAX_JOBS);

    // Write port: load of a new job or update of the running job
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_best_idx;
        w_wr_arr  = r_best_arr;
        w_wr_bur  = r_best_bur;
        w_wr_rem  = r_best_rem - BUR_W'(1);
        w_wr_done = (r_best_rem == BUR_W'(1)) ? (r_time + TIME_W'(1)) : r_best_done;
        if (i_cmd.load_wr) begin
            w_wr_en   = w_has_room;
            w_wr_addr = r_count[IDX_W-1:0];
            w_wr_arr  = i_in_data.arrival_time;
            w_wr_bur  = i_in_data.burst_length;
            w_wr_rem  = i_in_data.burst_length;
            w_wr_done = TIME_W'(i_in_data.arrival_time);
        end else if (i_cmd.time_step) begin
            w_wr_en = 1'b1;
        end
    end

    // Read port: scan or result readout
    assign w_rd_en   = i_cmd.scan_rd | i_cmd.out_rd;
    assign w_rd_addr = i_cmd.scan_rd ? r_scan_idx : r_out_idx;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem_arr[w_wr_addr]  <= w_wr_arr;
            mem_bur[w_wr_addr]  <= w_wr_bur;
            mem_rem[w_wr_addr]  <= w_wr_rem;
            mem_done[w_wr_addr] <= w_wr_done;
        end
        if (w_rd_en) begin
            r_rd_arr  <= mem_arr[w_rd_addr];
            r_rd_bur  <= mem_bur[w_rd_addr];
            r_rd_rem  <= mem_rem[w_rd_addr];
            r_rd_done <= mem_done[w_rd_addr];
        end
    end

    // Scan evaluation: longest remaining, then earlier arrival, then lower index
    assign w_unf     = r_rd_rem != '0;
    assign w_arrived = TIME_W'(r_rd_arr) <= r_time;
    assign w_better  = !r_best_vld || (r_rd_rem > r_best_rem) ||
                       ((r_rd_rem == r_best_rem) && (r_rd_arr < r_best_arr));

    // Result arithmetic
    assign w_tat      = r_rd_done - TIME_W'(r_rd_arr);
    assign w_wt       = (w_tat > TIME_W'(r_rd_bur)) ? (w_tat - TIME_W'(r_rd_bur)) : '0;
    assign w_out_last = (CNT_W'(r_out_idx) + CNT_W'(1)) == r_count;
    assign w_idx_out  = IDX_OUT_W'(r_out_idx);
    assign w_out_fire = r_out_valid & i_out_ready;
    assign w_skip_fwd = r_any_unf && (TIME_W'(r_min_arr) > r_time);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_time      <= '0;
            r_ovf       <= 1'b0;
            r_scan_idx  <= '0;
            r_eval_vld  <= 1'b0;
            r_best_vld  <= 1'b0;
            r_any_unf   <= 1'b0;
            r_out_idx   <= '0;
            r_out_valid <= 1'b0;
            r_tot_tat   <= '0;
            r_tot_wt    <= '0;
        end else begin
            r_eval_vld <= i_cmd.scan_rd;
            if (i_cmd.load_wr) begin
                if (w_has_room) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.scan_clr) begin
                r_scan_idx <= '0;
                r_best_vld <= 1'b0;
                r_any_unf  <= 1'b0;
            end else begin
                if (i_cmd.scan_rd) begin
                    r_scan_idx <= r_scan_idx + IDX_W'(1);
                end
                if (r_eval_vld && w_unf) begin
                    r_any_unf <= 1'b1;
                    if (w_arrived) begin
                        r_best_vld <= 1'b1;
                    end
                end
            end
            if (i_cmd.time_step) begin
                r_time <= r_time + TIME_W'(1);
            end else if (i_cmd.time_skip) begin
                r_time <= TIME_W'(r_min_arr);
            end
            if (i_cmd.out_clr) begin
                r_out_idx <= '0;
                r_tot_tat <= '0;
                r_tot_wt  <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_idx   <= r_out_idx + IDX_W'(1);
                r_tot_tat   <= r_tot_tat + TOT_W'(w_tat);
                r_tot_wt    <= r_tot_wt + TOT_W'(w_wt);
                r_out_valid <= 1'b1;
            end else if (w_out_fire) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.set_clear) begin
                r_count <= '0;
                r_time  <= '0;
                r_ovf   <= 1'b0;
            end
        end
    end

    // Scan payload: best candidate and earliest unfinished arrival
    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_rd) begin
            r_eval_idx <= r_scan_idx;
        end
        if (r_eval_vld && w_unf) begin
            if (!r_any_unf || (r_rd_arr < r_min_arr)) begin
                r_min_arr <= r_rd_arr;
            end
            if (w_arrived && w_better) begin
                r_best_idx  <= r_eval_idx;
                r_best_arr  <= r_rd_arr;
                r_best_bur  <= r_rd_bur;
                r_best_rem  <= r_rd_rem;
                r_best_done <= r_rd_done;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data.job_index        <= w_idx_out;
            r_out_data.completion_time  <= r_rd_done[RES_W-1:0];
            r_out_data.turnaround       <= w_tat[RES_W-1:0];
            r_out_data.waiting          <= w_wt[RES_W-1:0];
            r_out_data.total_turnaround <= r_tot_tat + TOT_W'(w_tat);
            r_out_data.total_waiting    <= r_tot_wt + TOT_W'(w_wt);
            r_out_data.overflowed       <= r_ovf;
            r_out_data.last_result      <= w_out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_status            = '0;
        o_status.idx_last   = (CNT_W'(r_scan_idx) + CNT_W'(1)) == r_count;
        o_status.best_valid = r_best_vld;
        o_status.any_unf    = r_any_unf;
        o_status.out_fire   = w_out_fire;
        o_status.res_last   = r_out_data.last_result;
    end

    // A unit of work only runs when the scan found a candidate
    `LRJS_ASSERT_IMPL(a_step_has_best, i_clk, i_rst_n, i_cmd.time_step, r_best_vld)
    // An idle skip must move time strictly forward
    `LRJS_ASSERT_IMPL(a_skip_forward, i_clk, i_rst_n, i_cmd.time_skip, w_skip_fwd)
    // A job offered to a full table marks the set as overflowed
    `LRJS_ASSERT_NEXT(a_full_flags, i_clk, i_rst_n, i_cmd.load_wr && !w_has_room, r_ovf)
    // Loading never overlaps a pending result
    `LRJS_ASSERT_IMPL(a_load_no_result, i_clk, i_rst_n, i_cmd.load_wr, !r_out_valid)

endmodule

>>> rtl/core/longest_remaining_job_scheduler.sv
// Channel  | Direction | Handshake                     | Beat
// ---------+-----------+-------------------------------+--------------------------
// job in   | input     | i_in_valid / o_in_ready       | i_in_data  (t_job_in)
// result   | output    | o_out_valid / i_out_ready     | o_out_data (t_job_res)
//
// Loading accepts one job beat per cycle; o_in_ready is low from the last job of a set
// until its final result beat is taken.
// Scheduling reads the job table through its single read port: each simulated time
// unit (or idle skip) scans all N stored jobs, then passes S_WAIT and S_DECIDE.
// Each result beat steps S_OUT_RD, S_OUT_CALC, S_OUT_HOLD and waits there on i_out_ready.
// Reset (i_rst_n low, synchronous) empties the job table count, time and overflow flag.
module longest_remaining_job_scheduler #(
    parameter int MAX_JOBS = lrjs_pkg::DEF_MAX_JOBS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lrjs_pkg::t_job_in  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lrjs_pkg::t_job_res o_out_data
);
    import lrjs_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    // Sequencer
    lrjs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last_job (i_in_data.last_job),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Job table, scan unit and result register
    lrjs_dp #(
        .MAX_JOBS (MAX_JOBS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> verif/lrjs_sched_checker.sv
module lrjs_sched_checker #(
    parameter int MAX_JOBS = lrjs_pkg::DEF_MAX_JOBS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  lrjs_pkg::t_job_in  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  lrjs_pkg::t_job_res i_out_data,
    output int                 o_err_cnt,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import lrjs_pkg::*;

    // Shadow job table of the current set
    logic [ARR_W-1:0] job_arr  [MAX_JOBS];
    logic [BUR_W-1:0] job_bur  [MAX_JOBS];
    int               job_left [MAX_JOBS];
    int               job_done [MAX_JOBS];
    int               job_cnt   = 0;
    bit               drop_seen = 0;

    t_job_res         sched_results_q [$];
    int               err_cnt = 0;

    assign o_err_cnt = err_cnt;

    // Preemptive longest-remaining-first run over the stored set, then one
    // expected result beat per stored job in load order.
    function automatic void run_schedule();
        int       now, pick, nxt, tat, wt, sum_tat, sum_wt;
        bit       running;
        t_job_res res;
        now     = 0;
        running = 1'b1;
        while (running) begin
            pick = -1;
            for (int i = 0; i < job_cnt; i++) begin
                if (job_left[i] != 0 && int'(job_arr[i]) <= now &&
                    (pick < 0 || job_left[i] > job_left[pick] ||
                     (job_left[i] == job_left[pick] && job_arr[i] < job_arr[pick])))
                    pick = i;
            end
            if (pick >= 0) begin
                job_left[pick]--;
                now++;
                if (job_left[pick] == 0)
                    job_done[pick] = now;
            end else begin
                // nothing arrived yet: jump to the next arrival, or stop
                nxt = -1;
                for (int i = 0; i < job_cnt; i++) begin
                    if (job_left[i] != 0 && (nxt < 0 || int'(job_arr[i]) < nxt))
                        nxt = int'(job_arr[i]);
                end
                if (nxt < 0)
                    running = 1'b0;
                else
                    now = nxt;
            end
        end

        sum_tat = 0;
        sum_wt  = 0;
        for (int i = 0; i < job_cnt; i++) begin
            tat      = job_done[i] - int'(job_arr[i]);
            wt       = (tat > int'(job_bur[i])) ? tat - int'(job_bur[i]) : 0;
            sum_tat += tat;
            sum_wt  += wt;
            res.job_index        = IDX_OUT_W'(i);
            res.completion_time  = RES_W'(job_done[i]);
            res.turnaround       = RES_W'(tat);
            res.waiting          = RES_W'(wt);
            res.total_turnaround = TOT_W'(sum_tat);
            res.total_waiting    = TOT_W'(sum_wt);
            res.overflowed       = drop_seen;
            res.last_result      = (i == job_cnt - 1);
            sched_results_q.push_back(res);
        end
        job_cnt   = 0;
        drop_seen = 1'b0;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    // Watch both channels; result beats are compared before new jobs load
    always @(posedge i_clk) begin : mon
        t_job_res want;
        if (!i_rst_n) begin
            job_cnt   = 0;
            drop_seen = 1'b0;
            sched_results_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (sched_results_q.size() == 0) begin
                    $error("result beat for job %0d with no result expected",
                           i_out_data.job_index);
                    err_cnt++;
                end else begin
                    want = sched_results_q.pop_front();
                    check_field("job_index", want.job_index, i_out_data.job_index);
                    check_field("completion_time", want.completion_time,
                                i_out_data.completion_time);
                    check_field("turnaround", want.turnaround, i_out_data.turnaround);
                    check_field("waiting", want.waiting, i_out_data.waiting);
                    check_field("total_turnaround", want.total_turnaround,
                                i_out_data.total_turnaround);
                    check_field("total_waiting", want.total_waiting,
                                i_out_data.total_waiting);
                    check_field("overflowed", want.overflowed, i_out_data.overflowed);
                    check_field("last_result", want.last_result, i_out_data.last_result);
                end
            end
            if (i_in_valid && i_in_ready) begin
                // store the job, or drop it when the table is full
                if (job_cnt < MAX_JOBS) begin
                    job_arr[job_cnt]  = i_in_data.arrival_time;
                    job_bur[job_cnt]  = i_in_data.burst_length;
                    job_left[job_cnt] = int'(i_in_data.burst_length);
                    job_done[job_cnt] = int'(i_in_data.arrival_time);
                    job_cnt++;
                end else begin
                    drop_seen = 1'b1;
                end
                if (i_in_data.last_job)
                    run_schedule();
            end
        end
        o_pending <= sched_results_q.size();
    end

endmodule

>>> verif/tb_longest_remaining_job_scheduler.sv
module tb_longest_remaining_job_scheduler;
    timeunit 1ns;
    timeprecision 1ps;
    import lrjs_pkg::*;

    localparam int N_JOBS      = DEF_MAX_JOBS;
    localparam int N_ITEMS     = 370;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 8_000_000;

    logic     i_clk       = 1'b0;
    logic     i_rst_n     = 1'b0;
    logic     i_in_valid  = 1'b0;
    logic     o_in_ready;
    t_job_in  i_in_data   = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_job_res o_out_data;

    int          err_cnt;
    int          pending;
    int          n_sent   = 0;
    int unsigned cyc      = 0;
    bit          steady   = 1'b0;  // no idling on either side
    bit          hold_tgl = 1'b0;  // toggle starts a long receiver hold-off

    longest_remaining_job_scheduler #(
        .MAX_JOBS (N_JOBS)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    lrjs_sched_checker #(
        .MAX_JOBS (N_JOBS)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_err_cnt   (err_cnt),
        .o_pending   (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side ready: random stalls, steady stretch, long hold-off
    initial begin : out_ready_drv
        int hold_cnt;
        bit hold_seen;
        bit hold_arm;
        hold_cnt  = 0;
        hold_seen = 1'b0;
        hold_arm  = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_tgl != hold_seen) begin
                hold_seen = hold_tgl;
                hold_arm  = 1'b1;
            end
            // start the hold-off once a result beat is waiting
            if (hold_arm && o_out_valid) begin
                hold_arm = 1'b0;
                hold_cnt = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_out_ready <= 1'b0;
            end else if (steady) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 31);
            end
        end
    end

    // One job beat; valid is held until the beat is taken
    task automatic send_job(input int arr, input int bur, input bit last);
        while (!steady && $urandom_range(99) < 31) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= '{arrival_time: ARR_W'(arr), burst_length: BUR_W'(bur),
                        last_job: last};
        do @(posedge i_clk); while (!o_in_ready);
        n_sent++;
    endtask

    initial begin : stim
        int size, base, arr, bur, big_left, set_no, r;
        big_left = 10;
        set_no   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // smallest and largest single-job sets
        send_job(0, 1, 1'b1);
        send_job(4095, 4095, 1'b1);
        // idle gap before a later arrival
        send_job(0, 2, 1'b0);
        send_job(100, 3, 1'b1);
        // zero burst never runs
        send_job(7, 0, 1'b0);
        send_job(9, 1, 1'b1);
        // ties on remaining work, then on arrival, then on index
        send_job(5, 3, 1'b0);
        send_job(5, 3, 1'b0);
        send_job(4, 4, 1'b1);
        // table full, the job marked last is dropped
        for (int k = 0; k <= N_JOBS; k++)
            send_job(k * 200, 1 + k % 3, k == N_JOBS);

        // random sets
        while (n_sent < N_ITEMS) begin
            set_no++;
            steady <= (set_no >= 10 && set_no < 15);
            if (set_no == 6) begin
                // let every result drain before the next set
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
            if (set_no == 3)
                size = N_JOBS;
            else if ($urandom_range(99) < 10)
                size = $urandom_range(N_JOBS + 1, N_JOBS + 4);
            else
                size = $urandom_range(1, N_JOBS);
            base = $urandom_range(0, 4095 - 32);
            for (int k = 0; k < size; k++) begin
                if ($urandom_range(99) < 25)
                    arr = $urandom_range(0, 4095);
                else
                    arr = base + $urandom_range(0, 31);
                // long bursts are rare: each costs one table scan per unit
                r = $urandom_range(999);
                if (r < 30 && big_left > 0) begin
                    bur = $urandom_range(1, 4095);
                    big_left--;
                end else if (r < 200) begin
                    bur = $urandom_range(1, 63);
                end else begin
                    bur = $urandom_range(1, 8);
                end
                send_job(arr, bur, k == size - 1);
            end
            // full table: hold results back while the next set is offered
            if (set_no == 3)
                hold_tgl <= ~hold_tgl;
        end

        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (64) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
